// File: rtl/core/cov_pkg.sv
// ----------------------------------------------------------------------------
// cov_pkg
// Shared constants and widths for the covariance matrix block.
// ----------------------------------------------------------------------------
package cov_pkg;

    localparam int MAX_VARS    = 8;
    localparam int MAX_SAMPLES = 256;

    localparam int VAR_W   = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int SMP_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int VCNT_W  = VAR_W + 1;         // effective variable count
    localparam int SCNT_W  = SMP_W + 1;         // effective sample count
    localparam int ADDR_W  = SMP_W + VAR_W;
    localparam int DEPTH   = 1 << ADDR_W;

    localparam int VAL_W   = 16;                // input word, Q7.8
    localparam int SUM_W   = VAL_W + SMP_W;
    localparam int DIFF_W  = VAL_W + 2;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = PROD_W + SMP_W;
    localparam int OUT_W   = 2 * VAL_W + 2;     // 34-bit result
    localparam int IDX_W   = 3;                 // row/col field width

    localparam int CFG_VW  = 4;                 // var_count register width
    localparam int CFG_SW  = 9;                 // sample_count register width
    localparam int CFG_W   = 9;
    localparam int CFG_AW  = 1;

    localparam logic [CFG_AW-1:0] CFG_VARS = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_SMPS = 1'd1;

endpackage

// File: rtl/core/covariance_matrix_top.sv
// ----------------------------------------------------------------------------
// covariance_matrix_top
// Population covariance matrix of a loaded fixed-point data set.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_value) carries Q7.8 words, sample by
//   sample, all variables of a sample in turn. One word is taken per cycle
//   while loading; o_stall is high during the compute sweep.
//   Output channel (o_valid / i_stall) carries var_count^2 words in row-major
//   order, Q.16, row and column index, last on the final entry. A result is
//   held until taken; the sweep waits while the receiver stalls.
//   Configuration: i_cfg_we writes var_count (index 0) or sample_count
//   (index 1); zero acts as one, large values saturate. A write drops any
//   partly loaded set. Reset sets both counts to one, clears the sums.
// Sequence:
//   After the last word, each mean takes one divide. Each entry then passes
//   the mean-select states, a read of every sample of its two variables
//   through the mirrored memories, a drain of the accumulator pipeline, a
//   divide and the output state, which waits while the receiver stalls. The
//   sample memory reads and the bit-serial divider bound the speed.
// ----------------------------------------------------------------------------
module covariance_matrix_top
    import cov_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_cov_value,
    output logic [IDX_W-1:0]        o_row_index,
    output logic [IDX_W-1:0]        o_col_index,
    output logic                    o_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_MEAN_GO = 4'd1;
    localparam logic [3:0] S_MEAN_WT = 4'd2;
    localparam logic [3:0] S_MA      = 4'd3;
    localparam logic [3:0] S_MB      = 4'd4;
    localparam logic [3:0] S_MAC     = 4'd5;
    localparam logic [3:0] S_DRAIN   = 4'd6;
    localparam logic [3:0] S_DIV_GO  = 4'd7;
    localparam logic [3:0] S_DIV_WT  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    localparam logic signed [ACC_W-1:0] LIM_HI =
        {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] LIM_LO = ~LIM_HI;

    logic [3:0]        r_state;
    logic [VCNT_W-1:0] r_nv;
    logic [SCNT_W-1:0] r_ns;
    logic [VAR_W-1:0]  r_var, r_k, r_i, r_j;
    logic [SMP_W-1:0]  r_smp, r_s;
    logic              r_rd_vld;

    logic signed [SUM_W-1:0] r_sum  [MAX_VARS];
    logic signed [VAL_W-1:0] r_mean [MAX_VARS];
    logic signed [VAL_W-1:0] r_ma, r_mb;

    logic                    r_oval, r_olast;
    logic signed [OUT_W-1:0] r_ocov;
    logic [IDX_W-1:0]        r_orow, r_ocol;

    logic                    in_acc, out_acc;
    logic                    last_var, last_smp, last_s, last_i, last_j;
    logic [ADDR_W-1:0]       waddr, raddr_a, raddr_b;
    logic [VAL_W-1:0]        rdata_a, rdata_b;
    logic                    div_start, div_done;
    logic signed [ACC_W-1:0] div_num, div_q, acc;
    logic                    mac_busy;
    logic signed [OUT_W-1:0] sat_q;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_oval && !i_stall;
    assign last_var = (VCNT_W'(r_var) + VCNT_W'(1)) == r_nv;
    assign last_smp = (SCNT_W'(r_smp) + SCNT_W'(1)) == r_ns;
    assign last_s   = (SCNT_W'(r_s) + SCNT_W'(1)) == r_ns;
    assign last_i   = (VCNT_W'(r_i) + VCNT_W'(1)) == r_nv;
    assign last_j   = (VCNT_W'(r_j) + VCNT_W'(1)) == r_nv;

    assign waddr   = {r_smp, r_var};
    assign raddr_a = {r_s, r_i};
    assign raddr_b = {r_s, r_j};

    // Two mirrored copies of the sample store, one per operand of the product
    cov_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    cov_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    cov_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (r_state == S_MA),
        .i_vld   (r_rd_vld),
        .i_a     ($signed(rdata_a)),
        .i_b     ($signed(rdata_b)),
        .i_ma    (r_ma),
        .i_mb    (r_mb),
        .o_acc   (acc),
        .o_busy  (mac_busy)
    );

    // Divider shared between the means and the final scaling
    assign div_start = (r_state == S_MEAN_GO) || (r_state == S_DIV_GO);
    assign div_num   = (r_state == S_MEAN_GO) ? ACC_W'(r_sum[r_k]) : acc;

    cov_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (r_ns),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        if (div_q > LIM_HI) begin
            sat_q = LIM_HI[OUT_W-1:0];
        end else if (div_q < LIM_LO) begin
            sat_q = LIM_LO[OUT_W-1:0];
        end else begin
            sat_q = div_q[OUT_W-1:0];
        end
    end

    // Mean selection (one read of the mean array per cycle), mean write-back and result capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_MA) begin
            r_ma <= r_mean[r_i];
        end
        if (r_state == S_MB) begin
            r_mb <= r_mean[r_j];
        end
        if (r_state == S_MEAN_WT && div_done) begin
            r_mean[r_k] <= div_q[VAL_W-1:0];
        end
        if (r_state == S_DIV_WT && div_done) begin
            r_ocov  <= sat_q;
            r_orow  <= IDX_W'(r_i);
            r_ocol  <= IDX_W'(r_j);
            r_olast <= last_i && last_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_nv     <= VCNT_W'(1);
            r_ns     <= SCNT_W'(1);
            r_var    <= '0;
            r_smp    <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_s      <= '0;
            r_rd_vld <= 1'b0;
            r_oval   <= 1'b0;
            for (int v = 0; v < MAX_VARS; v++) begin
                r_sum[v] <= '0;
            end
        end else begin
            r_rd_vld <= (r_state == S_MAC);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VARS: begin
                        if (i_cfg_data[CFG_VW-1:0] == '0) begin
                            r_nv <= VCNT_W'(1);
                        end else if (i_cfg_data[CFG_VW-1:0] > CFG_VW'(MAX_VARS)) begin
                            r_nv <= VCNT_W'(MAX_VARS);
                        end else begin
                            r_nv <= VCNT_W'(i_cfg_data[CFG_VW-1:0]);
                        end
                    end
                    CFG_SMPS: begin
                        if (i_cfg_data[CFG_SW-1:0] == '0) begin
                            r_ns <= SCNT_W'(1);
                        end else if (i_cfg_data[CFG_SW-1:0] > CFG_SW'(MAX_SAMPLES)) begin
                            r_ns <= SCNT_W'(MAX_SAMPLES);
                        end else begin
                            r_ns <= SCNT_W'(i_cfg_data[CFG_SW-1:0]);
                        end
                    end
                    default: ;
                endcase
                r_var <= '0;
                r_smp <= '0;
                for (int v = 0; v < MAX_VARS; v++) begin
                    r_sum[v] <= '0;
                end
            end else begin
                unique case (r_state)
                    S_LOAD: begin
                        if (in_acc) begin
                            r_sum[r_var] <= r_sum[r_var] + SUM_W'(i_value);
                            if (last_var) begin
                                r_var <= '0;
                                if (last_smp) begin
                                    r_smp   <= '0;
                                    r_k     <= '0;
                                    r_state <= S_MEAN_GO;
                                end else begin
                                    r_smp <= r_smp + 1'b1;
                                end
                            end else begin
                                r_var <= r_var + 1'b1;
                            end
                        end
                    end
                    S_MEAN_GO: r_state <= S_MEAN_WT;
                    S_MEAN_WT: begin
                        if (div_done) begin
                            if ((VCNT_W'(r_k) + VCNT_W'(1)) == r_nv) begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_state <= S_MA;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_MEAN_GO;
                            end
                        end
                    end
                    S_MA: r_state <= S_MB;
                    S_MB: begin
                        r_s     <= '0;
                        r_state <= S_MAC;
                    end
                    S_MAC: begin
                        if (last_s) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_s <= r_s + 1'b1;
                        end
                    end
                    S_DRAIN: begin
                        if (!r_rd_vld && !mac_busy) begin
                            r_state <= S_DIV_GO;
                        end
                    end
                    S_DIV_GO: r_state <= S_DIV_WT;
                    S_DIV_WT: begin
                        if (div_done) begin
                            r_oval  <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        if (out_acc) begin
                            r_oval <= 1'b0;
                            if (last_j) begin
                                r_j <= '0;
                                if (last_i) begin
                                    r_i     <= '0;
                                    r_state <= S_LOAD;
                                    for (int v = 0; v < MAX_VARS; v++) begin
                                        r_sum[v] <= '0;
                                    end
                                end else begin
                                    r_i     <= r_i + 1'b1;
                                    r_state <= S_MA;
                                end
                            end else begin
                                r_j     <= r_j + 1'b1;
                                r_state <= S_MA;
                            end
                        end
                    end
                    default: r_state <= S_LOAD;
                endcase
            end
        end
    end

    assign o_stall     = (r_state != S_LOAD);
    assign o_valid     = r_oval;
    assign o_cov_value = r_ocov;
    assign o_row_index = r_orow;
    assign o_col_index = r_ocol;
    assign o_last      = r_olast;

    // The divider only finishes while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MEAN_WT || r_state == S_DIV_WT))
        else $error("divider result with no waiting state");

    // The final entry returns the block to loading
    a_last_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last && !i_cfg_we) |=> (r_state == S_LOAD))
        else $error("last entry did not restart loading");

    // Memory reads feed the accumulator only from the sweep
    a_read_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_MAC || r_state == S_DRAIN))
        else $error("sample read outside the sweep");

    // A result stays offered only in the output state
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT))
        else $error("result offered outside the output state");

endmodule

// File: rtl/core/cov_ram.sv
// ----------------------------------------------------------------------------
// cov_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cov_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cov_div.sv
// ----------------------------------------------------------------------------
// cov_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module cov_div
    import cov_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_dividend,
    input  logic [SCNT_W-1:0]       i_divisor,
    output logic                    o_done,
    output logic signed [ACC_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic              r_busy, r_done, r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [SCNT_W-1:0] r_div;
    logic [SCNT_W-1:0] r_rem;
    logic [ACC_W-1:0]  r_quo;

    logic [SCNT_W:0]   trial;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_quo[ACC_W-1]};
        ge    = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ACC_W);
                r_neg  <= i_dividend[ACC_W-1];
                r_quo  <= i_dividend[ACC_W-1] ? -i_dividend : i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? SCNT_W'(trial - {1'b0, r_div}) : trial[SCNT_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// File: rtl/core/cov_mac.sv
// ----------------------------------------------------------------------------
// cov_mac
// Centering, multiply and accumulate pipeline for one covariance entry.
// ----------------------------------------------------------------------------
module cov_mac
    import cov_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clr,
    input  logic                    i_vld,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    input  logic signed [VAL_W-1:0] i_ma,
    input  logic signed [VAL_W-1:0] i_mb,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_busy
);

    logic                     r_v1, r_v2;
    logic signed [DIFF_W-1:0] r_da, r_db;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_da   <= DIFF_W'(i_a) - DIFF_W'(i_ma);
        r_db   <= DIFF_W'(i_b) - DIFF_W'(i_mb);
        r_prod <= PROD_W'(r_da) * PROD_W'(r_db);
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v1 | r_v2;

endmodule
